>>> rtl/core/dpa_pkg.sv
// Shared types, constants and helper functions for the float32 dot product core.
// No dependencies; dpa_fifo, dpa_front, dpa_back and the top level import this package.
package dpa_pkg;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  localparam logic [31:0] QnanBits = 32'h7FC0_0000;
  localparam logic [30:0] InfMag   = 31'h7F80_0000;

  typedef logic signed [11:0] exp_t;

  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        zero;
    logic        sign;
    logic        last;
    logic [47:0] mant;
    exp_t        expo;
  } q_entry_t;

  function automatic logic [6:0] lead_zeros64(input logic [63:0] v);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) begin
        n = 7'(63 - i);
      end
    end
    return n;
  endfunction

endpackage

>>> rtl/core/dpa_pair_if.sv
// Input channel: one operand pair per beat, with the last marker.
// No dependencies.
interface dpa_pair_if;
  logic        valid;
  logic        ready;
  logic [31:0] a_value;
  logic [31:0] b_value;
  logic        last_pair;

  modport source (output valid, output a_value, output b_value, output last_pair, input ready);
  modport sink   (input valid, input a_value, input b_value, input last_pair, output ready);
endinterface

>>> rtl/core/dpa_sum_if.sv
// Output channel: one finished dot product per beat.
// No dependencies.
interface dpa_sum_if;
  logic        valid;
  logic        ready;
  logic [31:0] dot_sum;

  modport source (output valid, output dot_sum, input ready);
  modport sink   (input valid, input dot_sum, output ready);
endinterface

>>> rtl/core/dpa_fifo.sv
// Short queue of classified products between front and back.
// Depends on dpa_pkg.
module dpa_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dpa_pkg::q_entry_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output dpa_pkg::q_entry_t head_o
);
  import dpa_pkg::*;

  q_entry_t         mem_q [QDepth];
  logic [QPtrW:0]   wr_q, rd_q;

  assign empty_o = (wr_q == rd_q);
  assign full_o  = (wr_q[QPtrW] != rd_q[QPtrW]) && (wr_q[QPtrW-1:0] == rd_q[QPtrW-1:0]);
  assign head_o  = mem_q[rd_q[QPtrW-1:0]];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q[QPtrW-1:0]] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end
endmodule

>>> rtl/core/dpa_front.sv
// Front end: accept operand pairs, classify them, form and normalize the exact product.
// Depends on dpa_pkg and dpa_pair_if.
module dpa_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  dpa_pair_if.sink          pair_i,
  output logic              push_o,
  output dpa_pkg::q_entry_t entry_o,
  input  logic              full_i
);
  import dpa_pkg::*;

  logic        s1_v_q, s2_v_q;
  logic [31:0] a_q, b_q;
  logic        last1_q;
  logic        s1_en, s2_en;

  logic [7:0]  ea, eb;
  logic [22:0] fa, fb;
  logic        anan, bnan, ainf, binf, azero, bzero;
  exp_t        xa, xb;
  logic [47:0] prod;

  logic        nan_q, inf_q, zero_q, sign_q, last2_q;
  logic [47:0] prod_q;
  exp_t        xe0_q;
  logic [6:0]  lz;

  assign push_o      = s2_v_q && !full_i;
  assign s2_en       = !s2_v_q || push_o;
  assign s1_en       = !s1_v_q || s2_en;
  assign pair_i.ready = s1_en;

  always_comb begin
    ea    = a_q[30:23];
    eb    = b_q[30:23];
    fa    = a_q[22:0];
    fb    = b_q[22:0];
    anan  = (&ea) && (|fa);
    bnan  = (&eb) && (|fb);
    ainf  = (&ea) && !(|fa);
    binf  = (&eb) && !(|fb);
    azero = !(|ea) && !(|fa);
    bzero = !(|eb) && !(|fb);
    xa    = (ea == 8'd0) ? 12'sd1 : $signed({4'b0, ea});
    xb    = (eb == 8'd0) ? 12'sd1 : $signed({4'b0, eb});
    prod  = {|ea, fa} * {|eb, fb};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      a_q     <= '0;
      b_q     <= '0;
      last1_q <= 1'b0;
    end else if (s1_en) begin
      s1_v_q <= pair_i.valid;
      if (pair_i.valid) begin
        a_q     <= pair_i.a_value;
        b_q     <= pair_i.b_value;
        last1_q <= pair_i.last_pair;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      nan_q   <= 1'b0;
      inf_q   <= 1'b0;
      zero_q  <= 1'b0;
      sign_q  <= 1'b0;
      last2_q <= 1'b0;
      prod_q  <= '0;
      xe0_q   <= '0;
    end else if (s2_en) begin
      s2_v_q <= s1_v_q;
      if (s1_v_q) begin
        nan_q   <= anan || bnan || (ainf && bzero) || (binf && azero);
        inf_q   <= ainf || binf;
        zero_q  <= azero || bzero;
        sign_q  <= a_q[31] ^ b_q[31];
        last2_q <= last1_q;
        prod_q  <= prod;
        xe0_q   <= xa + xb - 12'sd300;
      end
    end
  end

  always_comb begin
    lz            = lead_zeros64({prod_q, 16'b0});
    entry_o.nan   = nan_q;
    entry_o.inf   = inf_q;
    entry_o.zero  = zero_q;
    entry_o.sign  = sign_q;
    entry_o.last  = last2_q;
    entry_o.mant  = prod_q << lz[5:0];
    entry_o.expo  = xe0_q - 12'sd14 - $signed({5'b0, lz});
  end
endmodule

>>> rtl/core/dpa_back.sv
// Back end: fused add of each product into the accumulator, rounding, result register.
// Depends on dpa_pkg and dpa_sum_if.
module dpa_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  dpa_pkg::q_entry_t head_i,
  output logic              pop_o,
  dpa_sum_if.source         sum_o
);
  import dpa_pkg::*;

  typedef enum logic [1:0] {S_ALIGN, S_ADD, S_NORM, S_ROUND} state_e;

  state_e      st_q;
  logic [31:0] acc_q;
  logic        spec_q, last_q;
  logic [31:0] spec_val_q;
  logic [63:0] big_q, small_q, sum_q;
  logic        dbig_q, bsign_q, ssign_q, sign_q;
  logic [5:0]  d_q;
  exp_t        bexp_q, e_q, sh_q;
  logic        out_v_q;
  logic [31:0] out_data_q;
  logic        emit;

  // align stage
  logic [7:0]  ec;
  logic [22:0] fc;
  logic        sc, cnan, cinf, czero;
  logic        a_spec;
  logic [31:0] a_val;
  logic [23:0] mc;
  exp_t        xc, ye, diff;
  logic [6:0]  lzc;
  logic [63:0] x61, y61, a_big, a_small;
  exp_t        a_bexp;
  logic        a_bsign, a_ssign;
  // add stage
  logic [63:0] mask, lost, sm, s_sum;
  logic        s_sign;
  // normalize stage
  logic [6:0]  lzs;
  logic [5:0]  p;
  exp_t        n_e, n_sh;
  // round stage
  exp_t        nsh, em1;
  logic [63:0] rmask, rem, half, q;
  logic [31:0] packed_bits, rounded, result;
  logic        done_ok;

  assign pop_o         = (st_q == S_ALIGN) && !empty_i;
  assign sum_o.valid   = out_v_q;
  assign sum_o.dot_sum = out_data_q;
  assign emit          = (st_q == S_ROUND) && done_ok && last_q;

  always_comb begin
    ec    = acc_q[30:23];
    fc    = acc_q[22:0];
    sc    = acc_q[31];
    cnan  = (&ec) && (|fc);
    cinf  = (&ec) && !(|fc);
    czero = !(|ec) && !(|fc);
    a_spec = 1'b1;
    if (head_i.nan || cnan) begin
      a_val = QnanBits;
    end else if (head_i.inf) begin
      a_val = (cinf && (sc != head_i.sign)) ? QnanBits : {head_i.sign, InfMag};
    end else if (cinf) begin
      a_val = acc_q;
    end else if (head_i.zero) begin
      a_val = czero ? ((head_i.sign == sc) ? {sc, 31'b0} : 32'b0) : acc_q;
    end else begin
      a_val  = acc_q;
      a_spec = 1'b0;
    end
    mc   = {|ec, fc};
    xc   = (ec == 8'd0) ? 12'sd1 : $signed({4'b0, ec});
    lzc  = lead_zeros64({mc, 40'b0});
    x61  = {2'b0, head_i.mant, 14'b0};
    y61  = {2'b0, mc << lzc[4:0], 38'b0};
    ye   = xc - 12'sd188 - $signed({5'b0, lzc});
    if (czero) begin
      a_big = x61; a_bexp = head_i.expo; a_bsign = head_i.sign;
      a_small = '0; a_ssign = head_i.sign; diff = '0;
    end else if (head_i.expo >= ye) begin
      a_big = x61; a_bexp = head_i.expo; a_bsign = head_i.sign;
      a_small = y61; a_ssign = sc; diff = head_i.expo - ye;
    end else begin
      a_big = y61; a_bexp = ye; a_bsign = sc;
      a_small = x61; a_ssign = head_i.sign; diff = ye - head_i.expo;
    end
  end

  always_comb begin
    mask = (64'd1 << d_q) - 64'd1;
    lost = small_q & mask;
    sm   = dbig_q ? {63'b0, |small_q} : ((small_q >> d_q) | {63'b0, |lost});
    if (bsign_q == ssign_q) begin
      s_sum = big_q + sm; s_sign = bsign_q;
    end else if (big_q >= sm) begin
      s_sum = big_q - sm; s_sign = bsign_q;
    end else begin
      s_sum = sm - big_q; s_sign = ssign_q;
    end
  end

  always_comb begin
    lzs  = lead_zeros64(sum_q);
    p    = 6'(7'd63 - lzs);
    n_e  = $signed({6'b0, p}) + bexp_q + 12'sd127;
    n_sh = (n_e >= 12'sd1) ? ($signed({6'b0, p}) - 12'sd23) : (-12'sd149 - bexp_q);
  end

  always_comb begin
    nsh   = -sh_q;
    em1   = e_q - 12'sd1;
    rmask = (64'd1 << sh_q[5:0]) - 64'd1;
    rem   = sum_q & rmask;
    half  = 64'd1 << (sh_q[5:0] - 6'd1);
    if (sh_q <= 12'sd0) begin
      q = sum_q << nsh[5:0];
    end else if (sh_q >= 12'sd64) begin
      q = '0;
    end else begin
      q = sum_q >> sh_q[5:0];
      if ((rem > half) || ((rem == half) && q[0])) begin
        q = q + 64'd1;
      end
    end
    packed_bits = (e_q < 12'sd1) ? q[31:0] : ({1'b0, em1[7:0], 23'b0} + q[31:0]);
    if ((e_q >= 12'sd255) || (packed_bits >= {1'b0, InfMag})) begin
      rounded = {sign_q, InfMag};
    end else begin
      rounded = {sign_q, packed_bits[30:0]};
    end
    result  = spec_q ? spec_val_q : rounded;
    done_ok = !last_q || !out_v_q || sum_o.ready;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_ALIGN;
      acc_q      <= '0;
      spec_q     <= 1'b0;
      spec_val_q <= '0;
      last_q     <= 1'b0;
      big_q      <= '0;
      small_q    <= '0;
      sum_q      <= '0;
      dbig_q     <= 1'b0;
      bsign_q    <= 1'b0;
      ssign_q    <= 1'b0;
      sign_q     <= 1'b0;
      d_q        <= '0;
      bexp_q     <= '0;
      e_q        <= '0;
      sh_q       <= '0;
      out_v_q    <= 1'b0;
      out_data_q <= '0;
    end else begin
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (sum_o.ready) begin
        out_v_q <= 1'b0;
      end
      unique case (st_q)
        S_ALIGN: begin
          if (!empty_i) begin
            spec_q     <= a_spec;
            spec_val_q <= a_val;
            last_q     <= head_i.last;
            big_q      <= a_big;
            small_q    <= a_small;
            bexp_q     <= a_bexp;
            bsign_q    <= a_bsign;
            ssign_q    <= a_ssign;
            dbig_q     <= (diff >= 12'sd63);
            d_q        <= diff[5:0];
            st_q       <= S_ADD;
          end
        end
        S_ADD: begin
          sum_q  <= s_sum;
          sign_q <= s_sign;
          st_q   <= S_NORM;
        end
        S_NORM: begin
          if (!spec_q && (sum_q == 64'd0)) begin
            spec_q     <= 1'b1;
            spec_val_q <= 32'b0;
          end
          e_q  <= n_e;
          sh_q <= n_sh;
          st_q <= S_ROUND;
        end
        S_ROUND: begin
          if (done_ok) begin
            if (last_q) begin
              acc_q      <= '0;
              out_data_q <= result;
            end else begin
              acc_q <= result;
            end
            st_q <= S_ALIGN;
          end
        end
        default: st_q <= S_ALIGN;
      endcase
    end
  end
endmodule

>>> rtl/core/float32_dot_product_accumulator_core.sv
// Top level of the float32 dot product core: front end, queue and accumulating back end.
// Depends on dpa_pkg, dpa_pair_if, dpa_sum_if, dpa_front, dpa_fifo and dpa_back.
//
//   channel  dir  beat contents                     accepted when
//   pair_i   in   a_value, b_value, last_pair       valid && ready
//   sum_o    out  dot_sum (once per last pair)      valid && ready
//
// The front takes one pair per cycle, unless the queue is full, into a two-stage multiply pipeline.
// The accumulator loop steps through align, add, normalize and round for each pair,
// so it takes no new pair until the last one is through; a 4-deep queue absorbs bursts.
// Reset clears the accumulator to +0 and empties pipeline, queue and result register.
// A waiting result stalls only the last pair of the next vector.
module float32_dot_product_accumulator_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  dpa_pair_if.sink  pair_i,
  dpa_sum_if.source sum_o
);
  import dpa_pkg::*;

  logic     push, full, pop, empty;
  q_entry_t push_data, head;

  dpa_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pair_i  (pair_i),
    .push_o  (push),
    .entry_o (push_data),
    .full_i  (full)
  );

  dpa_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  dpa_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .sum_o   (sum_o)
  );
endmodule
